### hw/rtl/cbeq_pkg.sv
// Shared types and constants of the cascaded biquad equalizer.
`default_nettype none

package cbeq_pkg;

   // Fixed-point formats
   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS   = 36;
   localparam int COEF_FRAC   = 28;
   localparam int DELAY_BITS  = 48;
   localparam int SIG_FRAC    = 16;
   localparam int GAIN_BITS   = 24;
   localparam int GAIN_FRAC   = 19;
   localparam int COEF_SLOTS  = 5;

   // Coefficient slots
   localparam logic [2:0] SLOT_B0 = 3'd0;
   localparam logic [2:0] SLOT_B1 = 3'd1;
   localparam logic [2:0] SLOT_B2 = 3'd2;
   localparam logic [2:0] SLOT_A1 = 3'd3;
   localparam logic [2:0] SLOT_A2 = 3'd4;

   // Request kinds
   localparam logic [1:0] ACT_FILTER = 2'd0;
   localparam logic [1:0] ACT_COEF   = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;
   localparam logic [1:0] ACT_RSVD   = 2'd3;

   // Channel modes that pass one channel through
   localparam logic [2:0] MODE_LEFT  = 3'd1;
   localparam logic [2:0] MODE_RIGHT = 3'd2;

   // Register indexes
   localparam logic [1:0] CSR_COUNT = 2'd0;
   localparam logic [1:0] CSR_MODE  = 2'd1;
   localparam logic [1:0] CSR_GAIN  = 2'd2;

   typedef logic signed [DELAY_BITS-1:0] sig_type;

   // Coefficient write into one band cell
   typedef struct packed {
      logic                        we;
      logic [2:0]                  slot;
      logic signed [COEF_BITS-1:0] value;
   } coef_wr_type;

endpackage

`default_nettype wire

### hw/rtl/cbeq_cell.sv
// One biquad band cell: coefficients, delay words and a shared multiplier.
`default_nettype none

module cbeq_cell #(
   parameter int NUM_CHANNELS = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  ch,
   input  wire cbeq_pkg::sig_type     s_in,
   input  wire cbeq_pkg::coef_wr_type coef_wr,
   input  wire logic                  clear,
   output logic                       done,
   output cbeq_pkg::sig_type          y_out
);

   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [3:0] STEP_Y    = 4'd2;
   localparam logic [3:0] STEP_T1   = 4'd4;
   localparam logic [3:0] STEP_T2   = 4'd6;
   localparam logic [3:0] STEP_Z1   = 4'd8;
   localparam logic [3:0] STEP_LAST = 4'd10;
   localparam logic signed [83:0] RND_HALF = 84'sd1 <<< (cbeq_pkg::COEF_FRAC - 1);

   logic signed [cbeq_pkg::COEF_BITS-1:0] coef_ff [cbeq_pkg::COEF_SLOTS];
   cbeq_pkg::sig_type z1_ff [NUM_CHANNELS];
   cbeq_pkg::sig_type z2_ff [NUM_CHANNELS];
   cbeq_pkg::sig_type s_ff, y_ff;
   logic signed [56:0] t1_ff, t2_ff;
   logic signed [83:0] acc_ff, acc_in;
   logic [3:0]         step_ff;
   logic               busy_ff, done_ff, ch_ff;

   logic signed [cbeq_pkg::COEF_BITS-1:0] coef_op;
   cbeq_pkg::sig_type  sig;
   logic signed [24:0] mul_b;
   logic signed [60:0] prod;
   logic signed [56:0] rnd;
   logic [CH_W-1:0]    ch_idx;
   logic signed [59:0] y_sum, z1_sum, z2_sum;

   function automatic cbeq_pkg::sig_type sat48(input logic signed [59:0] v);
      logic signed [59:0] hi;
      logic signed [59:0] lo;
      hi = (60'sd1 <<< (cbeq_pkg::DELAY_BITS - 1)) - 60'sd1;
      lo = -hi - 60'sd1;
      if (v > hi) begin
         sat48 = hi[47:0];
      end else if (v < lo) begin
         sat48 = lo[47:0];
      end else begin
         sat48 = v[47:0];
      end
   endfunction

   // Pick the coefficient and signal half for the current step
   always_comb begin
      case (step_ff[3:1])
         3'd0:    coef_op = coef_ff[cbeq_pkg::SLOT_B0];
         3'd1:    coef_op = coef_ff[cbeq_pkg::SLOT_B1];
         3'd2:    coef_op = coef_ff[cbeq_pkg::SLOT_B2];
         3'd3:    coef_op = coef_ff[cbeq_pkg::SLOT_A1];
         3'd4:    coef_op = coef_ff[cbeq_pkg::SLOT_A2];
         default: coef_op = '0;
      endcase
   end

   assign sig    = (step_ff < STEP_T2) ? s_ff : y_ff;
   assign mul_b  = step_ff[0] ? {sig[47], sig[47:24]} : {1'b0, sig[23:0]};
   assign prod   = coef_op * mul_b;
   assign acc_in = step_ff[0] ? acc_ff + (84'(prod) <<< 24) : 84'(prod);
   assign rnd    = 57'((acc_ff + RND_HALF) >>> cbeq_pkg::COEF_FRAC);
   assign ch_idx = CH_W'(ch_ff);

   // Section sums
   assign y_sum  = 60'(rnd) + 60'(z1_ff[ch_idx]);
   assign z1_sum = 60'(t1_ff) - 60'(rnd) + 60'(z2_ff[ch_idx]);
   assign z2_sum = 60'(t2_ff) - 60'(rnd);

   // Sequence the five products of one section
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         for (int i = 0; i < cbeq_pkg::COEF_SLOTS; i++) begin
            coef_ff[i] <= (i == 0) ? (36'sd1 <<< cbeq_pkg::COEF_FRAC) : '0;
         end
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            z1_ff[c] <= '0;
            z2_ff[c] <= '0;
         end
      end else begin
         done_ff <= busy_ff && !start && (step_ff == STEP_LAST);
         if (coef_wr.we) begin
            coef_ff[coef_wr.slot] <= coef_wr.value;
         end
         if (clear) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               z1_ff[c] <= '0;
               z2_ff[c] <= '0;
            end
         end
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            s_ff    <= s_in;
            ch_ff   <= ch;
         end else if (busy_ff) begin
            acc_ff  <= acc_in;
            step_ff <= step_ff + 4'd1;
            if (step_ff == STEP_Y) begin
               y_ff <= sat48(y_sum);
            end
            if (step_ff == STEP_T1) begin
               t1_ff <= rnd;
            end
            if (step_ff == STEP_T2) begin
               t2_ff <= rnd;
            end
            if (step_ff == STEP_Z1) begin
               z1_ff[ch_idx] <= sat48(z1_sum);
            end
            if (step_ff == STEP_LAST) begin
               z2_ff[ch_idx] <= sat48(z2_sum);
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done  = done_ff;
   assign y_out = y_ff;

endmodule

`default_nettype wire

### hw/rtl/cascaded_biquad_equalizer_core.sv
// Top level of the cascaded biquad equalizer: request decode, band chain, output gain.
//
// Requests come in on req_* (tuser holds the kind, tdata the channel, sample
// and coefficient address and value). Coefficient writes and delay clears take
// effect at the accepting edge and give no response. A filter request gives
// exactly one response on rsp_* carrying the sample and its channel.
// The band chain is a row of cells, one per band; each cell runs its section
// through one shared 36x25 multiplier, forming each of its five products in
// two halves. A filtered sample passes the cells in turn and then the output
// gain; a passed-through sample goes straight to the response register.
// One request is in flight at a time; req_tready is high only while the
// block is idle. The response sits in an output register, so a new request is
// taken while the last response waits; a finished result then holds until
// rsp_tready frees the register.
// Synchronous reset restores unity coefficients, clears all delay words and
// the registers go to count 2, stereo mode and unity gain. Registers must be
// written through csr_we/csr_index/csr_wdata only while idle; the block has no guard.
`default_nettype none

module cascaded_biquad_equalizer_core #(
   parameter int NUM_BANDS    = 8,
   parameter int NUM_CHANNELS = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // fields from bit 0: channel, sample_in, coef_band, coef_slot, coef_value, pad
   input  wire logic [71:0] req_tdata,
   // fields from bit 0: action
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // fields from bit 0: sample_out, channel_out, pad
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RUN  = 3'd1;
   localparam logic [2:0] ST_MUL0 = 3'd2;
   localparam logic [2:0] ST_MUL1 = 3'd3;
   localparam logic [2:0] ST_RND  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;
   localparam logic signed [71:0] RND_HALF =
      72'sd1 <<< (cbeq_pkg::SIG_FRAC + cbeq_pkg::GAIN_FRAC - 1);

   logic [2:0]  state_ff;
   logic [1:0]  count_ff;
   logic [2:0]  mode_ff;
   logic [23:0] gain_ff;
   logic        rsp_valid_ff;
   logic [24:0] rsp_data_ff;
   logic signed [23:0] res_ff;
   logic        ch_ff, start_ff;
   cbeq_pkg::sig_type s0_ff, fin_ff;
   logic signed [71:0] acc_ff;

   logic        accept;
   logic        r_ch;
   logic signed [23:0] r_sample;
   logic [2:0]  r_band, r_slot;
   logic signed [35:0] r_value;
   logic [3:0]  cnt_eff;
   logic        pass;
   logic        out_free;
   logic signed [24:0] gain_b;
   logic signed [49:0] gprod;
   logic signed [36:0] grnd;
   logic signed [23:0] gsat;

   logic [NUM_BANDS:0] start_chain;
   cbeq_pkg::sig_type  sig_chain [NUM_BANDS+1];

   // Unpack the request
   assign r_ch     = req_tdata[0];
   assign r_sample = req_tdata[24:1];
   assign r_band   = req_tdata[27:25];
   assign r_slot   = req_tdata[30:28];
   assign r_value  = req_tdata[66:31];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Effective channel count and pass-through decision
   always_comb begin
      cnt_eff = (count_ff == 2'd0) ? 4'd1 : 4'(count_ff);
      if (cnt_eff > 4'(NUM_CHANNELS)) begin
         cnt_eff = 4'(NUM_CHANNELS);
      end
      pass = (4'(r_ch) >= cnt_eff) ||
             ((cnt_eff == 4'd2) && (((mode_ff == cbeq_pkg::MODE_LEFT) && r_ch) ||
                                    ((mode_ff == cbeq_pkg::MODE_RIGHT) && !r_ch)));
   end

   // Band chain
   assign start_chain[0] = start_ff;
   assign sig_chain[0]   = s0_ff;

   for (genvar b = 0; b < NUM_BANDS; b++) begin : g_band
      cbeq_pkg::coef_wr_type wr;
      always_comb begin
         wr.we    = accept && (req_tuser == cbeq_pkg::ACT_COEF) &&
                    (32'(r_band) == b) && (r_slot <= cbeq_pkg::SLOT_A2);
         wr.slot  = r_slot;
         wr.value = r_value;
      end
      cbeq_cell #(
         .NUM_CHANNELS(NUM_CHANNELS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .start   (start_chain[b]),
         .ch      (ch_ff),
         .s_in    (sig_chain[b]),
         .coef_wr (wr),
         .clear   (accept && (req_tuser == cbeq_pkg::ACT_CLEAR)),
         .done    (start_chain[b+1]),
         .y_out   (sig_chain[b+1])
      );
   end

   // Output gain: two partial products, then round and saturate
   assign gain_b = (state_ff == ST_MUL1) ? {fin_ff[47], fin_ff[47:24]}
                                         : {1'b0, fin_ff[23:0]};
   assign gprod  = $signed({1'b0, gain_ff}) * gain_b;
   assign grnd   = 37'((acc_ff + RND_HALF) >>> (cbeq_pkg::SIG_FRAC + cbeq_pkg::GAIN_FRAC));

   always_comb begin
      if (grnd > 37'sd8388607) begin
         gsat = 24'sh7FFFFF;
      end else if (grnd < -37'sd8388608) begin
         gsat = 24'sh800000;
      end else begin
         gsat = grnd[23:0];
      end
   end

   // Control sequencer and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= 2'd2;
         mode_ff      <= 3'd0;
         gain_ff      <= 24'd524288;
      end else begin
         start_ff <= accept && (req_tuser == cbeq_pkg::ACT_FILTER) && !pass;
         if (csr_we) begin
            unique case (csr_index)
               cbeq_pkg::CSR_COUNT: count_ff <= csr_wdata[1:0];
               cbeq_pkg::CSR_MODE:  mode_ff  <= csr_wdata[2:0];
               cbeq_pkg::CSR_GAIN:  gain_ff  <= csr_wdata;
               default: ;
            endcase
         end
         // Load or release the response register
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_tuser == cbeq_pkg::ACT_FILTER)) begin
                  ch_ff <= r_ch;
                  if (pass) begin
                     res_ff   <= r_sample;
                     state_ff <= ST_DONE;
                  end else begin
                     s0_ff    <= 48'(r_sample) <<< cbeq_pkg::SIG_FRAC;
                     state_ff <= ST_RUN;
                  end
               end
            end
            ST_RUN: begin
               if (start_chain[NUM_BANDS]) begin
                  fin_ff   <= sig_chain[NUM_BANDS];
                  state_ff <= ST_MUL0;
               end
            end
            ST_MUL0: begin
               acc_ff   <= 72'(gprod);
               state_ff <= ST_MUL1;
            end
            ST_MUL1: begin
               acc_ff   <= acc_ff + (72'(gprod) <<< 24);
               state_ff <= ST_RND;
            end
            ST_RND: begin
               res_ff   <= gsat;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_data_ff  <= {ch_ff, res_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

`ifndef ASSERT_OFF
   a_chain_done_in_run: assert property (@(posedge clock) disable iff (reset)
      start_chain[NUM_BANDS] |-> (state_ff == ST_RUN))
      else $error("band chain finished outside of run state");
   a_mul_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL0) |=> (state_ff == ST_MUL1))
      else $error("gain multiply skipped its upper half");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> !req_tready)
      else $error("request accepted while the chain runs");
`endif

endmodule

`default_nettype wire

### tb/cbeq_checker.sv
// Checker: watches the request and response channels, predicts and compares responses.
`default_nettype none

module cbeq_checker #(
   parameter int NUM_BANDS    = 8,
   parameter int NUM_CHANNELS = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [71:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_wdata,
   output int               fail_count,
   output int               pending_count,
   output int               rsp_seen
);

   typedef struct packed {
      logic signed [cbeq_pkg::SAMPLE_BITS-1:0] sample;
      logic                                    chan;
   } eq_out_type;

   logic signed [63:0] coef_mem [NUM_BANDS*cbeq_pkg::COEF_SLOTS];
   logic signed [63:0] z1_mem [NUM_CHANNELS*NUM_BANDS];
   logic signed [63:0] z2_mem [NUM_CHANNELS*NUM_BANDS];
   logic [1:0]  cnt_reg;
   logic [2:0]  mode_reg;
   logic [23:0] gain_reg;
   eq_out_type  eq_expected_q[$];

   // Floor shift of a signed value
   function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int n);
      return v >>> n;
   endfunction

   function automatic logic signed [63:0] clamp(logic signed [63:0] v, int bits);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   // Product shifted right by sh, rounded half up, split to stay in 64 bits
   function automatic logic signed [63:0] scaled_product(logic signed [63:0] a,
                                                         logic signed [63:0] b, int sh);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = floor_shift(b, sh);
      lo = b - (hi <<< sh);
      return a * hi + floor_shift(a * lo + (64'sd1 <<< (sh - 1)), sh);
   endfunction

   // Run one filter request: pass-through check, then the band cascade and output gain
   function automatic eq_out_type equalize(logic chan, logic signed [23:0] x);
      eq_out_type r;
      int eff;
      int d;
      int base;
      logic signed [63:0] s;
      logic signed [63:0] y;
      logic signed [63:0] c0, c1, c2, c3, c4;
      eff = (cnt_reg == 2'd0) ? 1 : int'(cnt_reg);
      if (eff > NUM_CHANNELS) eff = NUM_CHANNELS;
      r.chan = chan;
      if (int'(chan) >= eff ||
          (eff == 2 && ((mode_reg == cbeq_pkg::MODE_LEFT && chan) ||
                        (mode_reg == cbeq_pkg::MODE_RIGHT && !chan)))) begin
         r.sample = x;
         return r;
      end
      s = 64'(x) <<< cbeq_pkg::SIG_FRAC;
      for (int b = 0; b < NUM_BANDS; b++) begin
         d    = int'(chan) * NUM_BANDS + b;
         base = b * cbeq_pkg::COEF_SLOTS;
         c0 = coef_mem[base + int'(cbeq_pkg::SLOT_B0)];
         c1 = coef_mem[base + int'(cbeq_pkg::SLOT_B1)];
         c2 = coef_mem[base + int'(cbeq_pkg::SLOT_B2)];
         c3 = coef_mem[base + int'(cbeq_pkg::SLOT_A1)];
         c4 = coef_mem[base + int'(cbeq_pkg::SLOT_A2)];
         y = clamp(scaled_product(c0, s, cbeq_pkg::COEF_FRAC) + z1_mem[d],
                   cbeq_pkg::DELAY_BITS);
         z1_mem[d] = clamp(scaled_product(c1, s, cbeq_pkg::COEF_FRAC) -
                           scaled_product(c3, y, cbeq_pkg::COEF_FRAC) + z2_mem[d],
                           cbeq_pkg::DELAY_BITS);
         z2_mem[d] = clamp(scaled_product(c2, s, cbeq_pkg::COEF_FRAC) -
                           scaled_product(c4, y, cbeq_pkg::COEF_FRAC),
                           cbeq_pkg::DELAY_BITS);
         s = y;
      end
      r.sample = 24'(clamp(scaled_product($signed({40'd0, gain_reg}), s,
                                          cbeq_pkg::SIG_FRAC + cbeq_pkg::GAIN_FRAC),
                           cbeq_pkg::SAMPLE_BITS));
      return r;
   endfunction

   always @(posedge clock) begin
      eq_out_type got;
      eq_out_type want;
      logic [2:0] band;
      logic [2:0] slot;
      if (reset) begin
         for (int i = 0; i < NUM_BANDS*cbeq_pkg::COEF_SLOTS; i++)
            coef_mem[i] = (i % cbeq_pkg::COEF_SLOTS == 0) ?
                          (64'sd1 <<< cbeq_pkg::COEF_FRAC) : 64'sd0;
         for (int i = 0; i < NUM_CHANNELS*NUM_BANDS; i++) begin
            z1_mem[i] = 64'sd0;
            z2_mem[i] = 64'sd0;
         end
         cnt_reg  = 2'd2;
         mode_reg = 3'd0;
         gain_reg = 24'd524288;
         eq_expected_q.delete();
         fail_count    = 0;
         rsp_seen      = 0;
         pending_count = 0;
      end else begin
         // Check a response against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            got.sample = rsp_tdata[23:0];
            got.chan   = rsp_tdata[24];
            if (eq_expected_q.size() == 0) begin
               $error("unexpected response %h", rsp_tdata);
               fail_count++;
            end else begin
               want = eq_expected_q.pop_front();
               if (got.sample !== want.sample) begin
                  $error("sample_out expected %0d actual %0d", want.sample, got.sample);
                  fail_count++;
               end
               if (got.chan !== want.chan) begin
                  $error("channel_out expected %0d actual %0d", want.chan, got.chan);
                  fail_count++;
               end
            end
         end
         // Predict an accepted request
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               cbeq_pkg::ACT_FILTER: begin
                  eq_expected_q.push_back(equalize(req_tdata[0], req_tdata[24:1]));
               end
               cbeq_pkg::ACT_COEF: begin
                  band = req_tdata[27:25];
                  slot = req_tdata[30:28];
                  if (int'(band) < NUM_BANDS && int'(slot) < cbeq_pkg::COEF_SLOTS)
                     coef_mem[int'(band)*cbeq_pkg::COEF_SLOTS+int'(slot)] =
                        64'($signed(req_tdata[66:31]));
               end
               cbeq_pkg::ACT_CLEAR: begin
                  for (int i = 0; i < NUM_CHANNELS*NUM_BANDS; i++) begin
                     z1_mem[i] = 64'sd0;
                     z2_mem[i] = 64'sd0;
                  end
               end
               default: ;
            endcase
         end
         // Track register writes
         if (csr_we) begin
            case (csr_index)
               cbeq_pkg::CSR_COUNT: cnt_reg  = csr_wdata[1:0];
               cbeq_pkg::CSR_MODE:  mode_reg = csr_wdata[2:0];
               cbeq_pkg::CSR_GAIN:  gain_reg = csr_wdata;
               default: ;
            endcase
         end
         pending_count = eq_expected_q.size();
      end
   end

endmodule

`default_nettype wire

### tb/tb_cascaded_biquad_equalizer_core.sv
// Testbench top: stimulus, register phases and verdict for the equalizer core.
`default_nettype none

module tb_cascaded_biquad_equalizer_core;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // fields from bit 0: channel, sample_in, coef_band, coef_slot, coef_value, pad
   logic [71:0] req_tdata;
   // fields from bit 0: action
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // fields from bit 0: sample_out, channel_out, pad
   logic [31:0] rsp_tdata;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [23:0] csr_wdata;

   int  fail_count;
   int  pending_count;
   int  rsp_seen;
   int  cycle_count;
   int  req_sent;
   bit  calm_phase;
   bit  long_hold;

   localparam int CYCLE_LIMIT = 600000;

   cascaded_biquad_equalizer_core i_dut (.*);

   cbeq_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Abort a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Response side: random bursts of back-pressure, plus one long hold
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offer one request; valid stays up until the next idle gap or drain
   task automatic send_req(logic [1:0] act, logic chan, logic [23:0] smp,
                           logic [2:0] band, logic [2:0] slot, logic [35:0] val);
      if (!calm_phase && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {5'd0, val, slot, band, smp, chan};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      req_sent++;
   endtask

   task automatic send_sample(logic chan, logic [23:0] smp);
      send_req(cbeq_pkg::ACT_FILTER, chan, smp, 3'd0, 3'd0, 36'd0);
   endtask

   task automatic send_coef(logic [2:0] band, logic [2:0] slot, logic [35:0] val);
      send_req(cbeq_pkg::ACT_COEF, 1'($urandom), 24'($urandom), band, slot, val);
   endtask

   // Wait for all responses, then for the cascade latency
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [23:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // Small stable coefficient near the identity, random sign and content
   function automatic logic [35:0] mild_coef(int slot);
      int r;
      r = $urandom_range(0, 1 << 26) - (1 << 25);
      if (slot == 0) return 36'(r + (1 << 28));
      return 36'($signed(r) >>> 2);
   endfunction

   initial begin
      logic [23:0] gains [4];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cycle_count = 0;
      req_sent = 0;
      calm_phase = 1'b0;
      long_hold = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes through unity bands, pass-through modes, odd requests
      send_sample(1'b0, 24'h7FFFFF);
      send_sample(1'b1, 24'h800000);
      send_sample(1'b0, 24'h000000);
      send_sample(1'b1, 24'hFFFFFF);
      send_coef(3'd0, cbeq_pkg::SLOT_B0, 36'h7FFFFFFFF);
      send_sample(1'b0, 24'h7FFFFF);
      send_sample(1'b0, 24'h800000);
      send_coef(3'd0, cbeq_pkg::SLOT_B0, 36'h800000000);
      send_sample(1'b1, 24'h123456);
      send_coef(3'd1, cbeq_pkg::SLOT_A1, 36'h0F0000000);
      send_coef(3'd1, cbeq_pkg::SLOT_A2, 36'hFF8000000);
      send_coef(3'd2, cbeq_pkg::SLOT_B1, 36'h008000000);
      send_coef(3'd2, cbeq_pkg::SLOT_B2, 36'hFFC000000);
      send_coef(3'd3, 3'd5, 36'hFFFFFFFFF);
      send_coef(3'd3, 3'd7, 36'h123456789);
      send_sample(1'b0, 24'h400000);
      send_sample(1'b0, 24'h000001);
      send_req(cbeq_pkg::ACT_RSVD, 1'b1, 24'h555555, 3'd7, 3'd7, 36'hAAAAAAAAA);
      send_req(cbeq_pkg::ACT_CLEAR, 1'b0, 24'd0, 3'd0, 3'd0, 36'd0);
      send_sample(1'b1, 24'hC00000);
      send_coef(3'd0, cbeq_pkg::SLOT_B0, 36'h010000000);
      drain();
      write_reg(cbeq_pkg::CSR_MODE, 24'(cbeq_pkg::MODE_LEFT));
      send_sample(1'b0, 24'h7FFFFF);
      send_sample(1'b1, 24'h7FFFFF);
      drain();
      write_reg(cbeq_pkg::CSR_MODE, 24'(cbeq_pkg::MODE_RIGHT));
      send_sample(1'b0, 24'h800000);
      send_sample(1'b1, 24'h800000);
      drain();

      // Random phases over register settings
      gains[0] = 24'd0;
      gains[1] = 24'hFFFFFF;
      gains[2] = 24'd524288;
      gains[3] = 24'd262144;
      for (int ph = 0; ph < 16; ph++) begin
         write_reg(cbeq_pkg::CSR_COUNT, 24'($urandom_range(0, 3)));
         write_reg(cbeq_pkg::CSR_MODE, 24'($urandom_range(0, 7)));
         write_reg(cbeq_pkg::CSR_GAIN, (ph < 4) ? gains[ph] : 24'($urandom));
         if (ph == 15) calm_phase = 1'b1;
         if (ph == 3) long_hold = 1'b1;
         for (int k = 0; k < 50; k++) begin
            case ($urandom_range(0, 19))
               0: send_coef(3'($urandom), 3'($urandom), 36'($urandom));
               1, 2: send_coef(3'($urandom), 3'($urandom_range(0, 4)),
                               mild_coef(int'($urandom_range(0, 4))));
               3: send_req(cbeq_pkg::ACT_CLEAR, 1'($urandom), 24'($urandom),
                           3'($urandom), 3'($urandom), 36'($urandom));
               4: send_req(cbeq_pkg::ACT_RSVD, 1'($urandom), 24'($urandom),
                           3'($urandom), 3'($urandom), 36'($urandom));
               default: send_sample(1'($urandom), 24'($urandom));
            endcase
         end
         // Sender pause until every response has arrived
         drain();
      end

      drain();
      $display("Sent %0d requests, checked %0d responses over 16 register phases",
               req_sent, rsp_seen);
      $display("covering pass-through modes, coefficient writes, clears and gain extremes");
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
